// File: hdl/ultrasonic_ranging_sequencer_top_macros.svh
// assertion helpers for the ranging sequencer
`ifndef ULTRASONIC_RANGING_SEQUENCER_TOP_MACROS_SVH
`define ULTRASONIC_RANGING_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define URS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define URS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define URS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define URS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/urs_pkg.sv
`default_nettype none

package urs_pkg;

    // field widths
    localparam int DIST_W    = 11;
    localparam int TMO_W     = 16;
    localparam int GAP_W     = 20;
    localparam int CNT_W     = 20;
    localparam int RES_W     = 6;
    localparam int NUM_SENS  = 3;
    localparam int IDX_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_GAP     = 2'd3;

    // register reset values
    localparam logic [DIST_W-1:0] RST_DIST_LIMIT    = 11'd400;
    localparam logic [TMO_W-1:0]  RST_START_TIMEOUT = 16'd10000;
    localparam logic [TMO_W-1:0]  RST_ECHO_TIMEOUT  = 16'd60000;
    localparam logic [GAP_W-1:0]  RST_ROUND_GAP     = 20'd100000;

    // trigger timing and conversion
    localparam logic [CNT_W-1:0]  TRIG_LOW_TICKS  = 20'd2;
    localparam logic [CNT_W-1:0]  TRIG_HIGH_TICKS = 20'd10;
    localparam logic [RES_W-1:0]  TICKS_PER_CM    = 6'd58;
    localparam logic [DIST_W-1:0] ACC_MAX         = 11'd2047;

    // sensor slots
    localparam logic [IDX_W-1:0] SENS_FRONT = 2'd0;
    localparam logic [IDX_W-1:0] SENS_LEFT  = 2'd1;
    localparam logic [IDX_W-1:0] SENS_RIGHT = 2'd2;

    typedef enum logic [4:0] {
        PH_TRIG_LOW  = 5'b00001,
        PH_TRIG_HIGH = 5'b00010,
        PH_WAIT_RISE = 5'b00100,
        PH_MEASURE   = 5'b01000,
        PH_GAP       = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_limit;
        logic [TMO_W-1:0]  start_timeout;
        logic [TMO_W-1:0]  echo_timeout;
        logic [GAP_W-1:0]  round_gap;
    } cfg_t;

    typedef struct packed {
        logic              trig_front;
        logic              trig_left;
        logic              trig_right;
        logic [DIST_W-1:0] front_cm;
        logic [DIST_W-1:0] left_cm;
        logic [DIST_W-1:0] right_cm;
        logic [2:0]        fail_mask;
        logic              report_valid;
    } result_t;

    typedef struct packed {
        phase_t           phase;
        logic [IDX_W-1:0] sensor_index;
    } status_t;

endpackage

`default_nettype wire

// File: hdl/urs_if.sv
`default_nettype none

// echo sample channel
interface urs_sample_if;
    logic valid;
    logic ready;
    logic echo_front;
    logic echo_left;
    logic echo_right;

    modport source (output valid, output echo_front, output echo_left, output echo_right,
                    input ready);
    modport sink (input valid, input echo_front, input echo_left, input echo_right,
                  output ready);
endinterface

// result channel
interface urs_result_if import urs_pkg::*;;
    logic              valid;
    logic              ready;
    logic              trig_front;
    logic              trig_left;
    logic              trig_right;
    logic [DIST_W-1:0] front_cm;
    logic [DIST_W-1:0] left_cm;
    logic [DIST_W-1:0] right_cm;
    logic [2:0]        fail_mask;
    logic              report_valid;

    modport source (output valid, output trig_front, output trig_left, output trig_right,
                    output front_cm, output left_cm, output right_cm,
                    output fail_mask, output report_valid, input ready);
    modport sink (input valid, input trig_front, input trig_left, input trig_right,
                  input front_cm, input left_cm, input right_cm,
                  input fail_mask, input report_valid, output ready);
endinterface

// register write channel
interface urs_cfg_if import urs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/urs_cfg_regs.sv
`default_nettype none

module urs_cfg_regs
    import urs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    urs_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register file, written one beat at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.dist_limit    <= RST_DIST_LIMIT;
            regs_reg.start_timeout <= RST_START_TIMEOUT;
            regs_reg.echo_timeout  <= RST_ECHO_TIMEOUT;
            regs_reg.round_gap     <= RST_ROUND_GAP;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DIST_LIMIT:    regs_reg.dist_limit    <= cfg.data[DIST_W-1:0];
                REG_START_TIMEOUT: regs_reg.start_timeout <= cfg.data[TMO_W-1:0];
                REG_ECHO_TIMEOUT:  regs_reg.echo_timeout  <= cfg.data[TMO_W-1:0];
                REG_ROUND_GAP:     regs_reg.round_gap     <= cfg.data[GAP_W-1:0];
                default:           regs_reg               <= regs_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/urs_seq.sv
`default_nettype none

module urs_seq
    import urs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [2:0]    echo,
    input  wire cfg_t          regs,
    output result_t            result,
    output status_t            status
);

    phase_t            phase_reg,  phase_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [RES_W-1:0]  res_reg,    res_next;
    logic [DIST_W-1:0] acc_reg,    acc_next;
    logic [DIST_W-1:0] dist_reg    [NUM_SENS];
    logic [DIST_W-1:0] dist_next   [NUM_SENS];
    logic [2:0]        err_reg,    err_next;

    assign status.phase        = phase_reg;
    assign status.sensor_index = idx_reg;

    // one tick of the ranging sequence
    always_comb
    begin
        logic              echo_sel;
        logic              measure;
        logic              done;
        logic              ok;
        logic              report;
        logic [2:0]        trig;
        logic [2:0]        err_shown;
        logic [CNT_W-1:0]  cnt_inc;
        logic [CNT_W-1:0]  m_cnt;
        logic [RES_W-1:0]  m_res;
        logic [DIST_W-1:0] m_acc;

        phase_next = phase_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        res_next   = res_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        for (int i = 0; i < NUM_SENS; i++)
        begin
            dist_next[i] = dist_reg[i];
        end
        measure = 1'b0;
        done    = 1'b0;
        ok      = 1'b0;
        report  = 1'b0;
        trig    = 3'b000;
        cnt_inc = count_reg + 1'b1;
        m_cnt   = count_reg;
        m_res   = res_reg;
        m_acc   = acc_reg;

        // echo of the sensor under measurement
        case (idx_reg)
            SENS_FRONT: echo_sel = echo[0];
            SENS_LEFT:  echo_sel = echo[1];
            default:    echo_sel = echo[2];
        endcase

        unique case (phase_reg)
            PH_TRIG_LOW:
            begin
                if (cnt_inc >= TRIG_LOW_TICKS)
                begin
                    phase_next = PH_TRIG_HIGH;
                    count_next = '0;
                end
                else
                begin
                    count_next = cnt_inc;
                end
            end
            PH_TRIG_HIGH:
            begin
                case (idx_reg)
                    SENS_FRONT: trig = 3'b001;
                    SENS_LEFT:  trig = 3'b010;
                    default:    trig = 3'b100;
                endcase
                if (cnt_inc >= TRIG_HIGH_TICKS)
                begin
                    phase_next = PH_WAIT_RISE;
                    count_next = '0;
                end
                else
                begin
                    count_next = cnt_inc;
                end
            end
            PH_WAIT_RISE:
            begin
                if (!echo_sel)
                begin
                    count_next = cnt_inc;
                    if (cnt_inc > CNT_W'(regs.start_timeout))
                    begin
                        done = 1'b1;
                    end
                end
                else
                begin
                    // rising edge counts as the first high tick
                    measure    = 1'b1;
                    phase_next = PH_MEASURE;
                    m_cnt      = '0;
                    m_res      = '0;
                    m_acc      = '0;
                end
            end
            PH_MEASURE:
            begin
                measure = 1'b1;
            end
            PH_GAP:
            begin
                count_next = cnt_inc;
                if (cnt_inc >= regs.round_gap)
                begin
                    phase_next = PH_TRIG_LOW;
                    idx_next   = SENS_FRONT;
                    count_next = '0;
                    err_next   = '0;
                end
            end
            default:
            begin
                phase_next = PH_TRIG_LOW;
                idx_next   = SENS_FRONT;
                count_next = '0;
                err_next   = '0;
            end
        endcase

        // echo high time, running quotient by ticks per cm
        if (measure)
        begin
            if (echo_sel)
            begin
                m_cnt = m_cnt + 1'b1;
                if (m_cnt > CNT_W'(regs.echo_timeout))
                begin
                    done = 1'b1;
                end
                else
                begin
                    m_res = m_res + 1'b1;
                    if (m_res >= TICKS_PER_CM)
                    begin
                        m_res = '0;
                        if (m_acc < ACC_MAX)
                        begin
                            m_acc = m_acc + 1'b1;
                        end
                    end
                end
            end
            else
            begin
                done = 1'b1;
                ok   = 1'b1;
            end
            count_next = m_cnt;
            res_next   = m_res;
            acc_next   = m_acc;
        end

        // close out the sensor
        if (done)
        begin
            if (ok)
            begin
                dist_next[idx_reg] = (m_acc < regs.dist_limit) ? m_acc : regs.dist_limit;
            end
            else
            begin
                err_next = err_next | (3'b001 << idx_reg);
            end
            count_next = '0;
            res_next   = '0;
            acc_next   = '0;
            if (idx_reg < SENS_RIGHT)
            begin
                idx_next   = idx_reg + 1'b1;
                phase_next = PH_TRIG_LOW;
            end
            else
            begin
                report = 1'b1;
                if (regs.round_gap == '0)
                begin
                    phase_next = PH_TRIG_LOW;
                    idx_next   = SENS_FRONT;
                end
                else
                begin
                    phase_next = PH_GAP;
                end
            end
        end

        err_shown = err_next;
        // zero gap: flags shown on the report beat, then cleared
        if (report && regs.round_gap == '0)
        begin
            err_next = '0;
        end

        result.trig_front   = trig[0];
        result.trig_left    = trig[1];
        result.trig_right   = trig[2];
        result.front_cm     = dist_next[0];
        result.left_cm      = dist_next[1];
        result.right_cm     = dist_next[2];
        result.fail_mask    = err_shown;
        result.report_valid = report;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TRIG_LOW;
            idx_reg   <= SENS_FRONT;
            count_reg <= '0;
            res_reg   <= '0;
            acc_reg   <= '0;
            err_reg   <= '0;
            for (int i = 0; i < NUM_SENS; i++)
            begin
                dist_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            res_reg   <= res_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
            for (int i = 0; i < NUM_SENS; i++)
            begin
                dist_reg[i] <= dist_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/urs_out_reg.sv
`default_nettype none

module urs_out_reg
    import urs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         load,
    input  wire result_t data,
    urs_result_if.source result
);

    logic    valid_reg;
    result_t data_reg;

    // take a new beat whenever the register is empty or draining
    assign in_ready = !valid_reg || result.ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign result.valid        = valid_reg;
    assign result.trig_front   = data_reg.trig_front;
    assign result.trig_left    = data_reg.trig_left;
    assign result.trig_right   = data_reg.trig_right;
    assign result.front_cm     = data_reg.front_cm;
    assign result.left_cm      = data_reg.left_cm;
    assign result.right_cm     = data_reg.right_cm;
    assign result.fail_mask    = data_reg.fail_mask;
    assign result.report_valid = data_reg.report_valid;

endmodule

`default_nettype wire

// File: hdl/ultrasonic_ranging_sequencer_top.sv
// A result beat appears in the cycle after its echo sample beat is accepted.
// Throughput: one sample per cycle while results drain; the sequencer state and
// result register update together, so the single-pass tick logic sets the rate.
// Reset (rst_n, async, active low): front sensor, trigger-low phase, distances and
// error flags zero, registers at their defaults; no clearing pass.
`default_nettype none
`include "ultrasonic_ranging_sequencer_top_macros.svh"

module ultrasonic_ranging_sequencer_top
    import urs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    urs_sample_if.sink   sample,
    urs_result_if.source result,
    urs_cfg_if.sink      cfg
);

    cfg_t    regs;
    result_t step_result;
    status_t status;
    logic    load;
    logic    in_ready;

    urs_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    urs_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (load),
        .echo   ({sample.echo_right, sample.echo_left, sample.echo_front}),
        .regs   (regs),
        .result (step_result),
        .status (status)
    );

    urs_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .load     (load),
        .data     (step_result),
        .result   (result)
    );

    assign sample.ready = in_ready;

    // at most one trigger driven per tick
    `URS_ASSERT_IMPL(a_trig_onehot, clk, rst_n, load,
        $onehot0({step_result.trig_right, step_result.trig_left, step_result.trig_front}),
        "more than one trigger driven")

    // trigger only in the trigger-high phase
    `URS_ASSERT_IMPL(a_trig_phase, clk, rst_n, load,
        ((step_result.trig_front | step_result.trig_left | step_result.trig_right)
            == (status.phase == PH_TRIG_HIGH)),
        "trigger level does not match phase")

    // a report leaves the sequencer in the gap or at the start of a round
    `URS_ASSERT_NEXT(a_report_next, clk, rst_n, load && step_result.report_valid,
        (status.phase == PH_GAP
            || (status.phase == PH_TRIG_LOW && status.sensor_index == SENS_FRONT)),
        "bad state after report")

endmodule

`default_nettype wire

// File: dv/ranging_checker.sv
`default_nettype none

module ranging_checker
    import urs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    urs_sample_if     sample,
    urs_result_if     result,
    urs_cfg_if        cfg,
    output int        fail_count,
    output int        pending_beats
);

    // shadow of the register file
    cfg_t              cfg_q;

    // shadow of the sequencer state
    phase_t            ph;
    logic [IDX_W-1:0]  sidx;
    logic [CNT_W-1:0]  pcnt;
    logic [RES_W-1:0]  resid;
    logic [DIST_W-1:0] acc;
    logic [DIST_W-1:0] stored_cm [NUM_SENS];
    logic [2:0]        round_err;

    // per-tick outputs still owed by the block
    result_t           expected_outputs [$];
    int                result_beats;

    // advance the shadow sequencer by one echo tick, bit0 front
    function automatic result_t step_sequencer(input logic [2:0] echo_in);
        result_t    r;
        logic [2:0] trig;
        logic       echo_bit;
        logic       done;
        logic       ok;
        logic       report;
        trig = '0;
        done = 1'b0;
        ok = 1'b0;
        report = 1'b0;
        echo_bit = echo_in[sidx];

        case (ph)
            PH_TRIG_LOW:
            begin
                pcnt++;
                if (pcnt >= TRIG_LOW_TICKS)
                begin
                    ph = PH_TRIG_HIGH;
                    pcnt = '0;
                end
            end
            PH_TRIG_HIGH:
            begin
                trig[sidx] = 1'b1;
                pcnt++;
                if (pcnt >= TRIG_HIGH_TICKS)
                begin
                    ph = PH_WAIT_RISE;
                    pcnt = '0;
                end
            end
            PH_WAIT_RISE:
            begin
                if (!echo_bit)
                begin
                    pcnt++;
                    if (pcnt > CNT_W'(cfg_q.start_timeout))
                        done = 1'b1;
                end
                else
                begin
                    ph = PH_MEASURE;
                    pcnt = '0;
                    resid = '0;
                    acc = '0;
                end
            end
            PH_GAP:
            begin
                pcnt++;
                if (pcnt >= cfg_q.round_gap)
                begin
                    ph = PH_TRIG_LOW;
                    sidx = SENS_FRONT;
                    pcnt = '0;
                    round_err = '0;
                end
            end
            default:
            begin
            end
        endcase

        // rise tick counts as the first high tick
        if (ph == PH_MEASURE)
        begin
            if (echo_bit)
            begin
                pcnt++;
                if (pcnt > CNT_W'(cfg_q.echo_timeout))
                    done = 1'b1;
                else
                begin
                    resid++;
                    if (resid >= TICKS_PER_CM)
                    begin
                        resid = '0;
                        if (acc < ACC_MAX)
                            acc++;
                    end
                end
            end
            else
            begin
                done = 1'b1;
                ok = 1'b1;
            end
        end

        // close out the sensor, keep old distance on failure
        if (done)
        begin
            if (ok)
                stored_cm[sidx] = (acc < cfg_q.dist_limit) ? acc : cfg_q.dist_limit;
            else
                round_err[sidx] = 1'b1;
            pcnt = '0;
            resid = '0;
            acc = '0;
            if (sidx < SENS_RIGHT)
            begin
                sidx++;
                ph = PH_TRIG_LOW;
            end
            else
            begin
                report = 1'b1;
                if (cfg_q.round_gap == '0)
                begin
                    ph = PH_TRIG_LOW;
                    sidx = SENS_FRONT;
                end
                else
                    ph = PH_GAP;
            end
        end

        r.trig_front   = trig[SENS_FRONT];
        r.trig_left    = trig[SENS_LEFT];
        r.trig_right   = trig[SENS_RIGHT];
        r.front_cm     = stored_cm[SENS_FRONT];
        r.left_cm      = stored_cm[SENS_LEFT];
        r.right_cm     = stored_cm[SENS_RIGHT];
        r.fail_mask    = round_err;
        r.report_valid = report;

        // zero gap: finished round's flags shown once, then cleared
        if (report && cfg_q.round_gap == '0)
            round_err = '0;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [DIST_W-1:0] want,
                                          input logic [DIST_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result beat %0d: %s expected %0d got %0d",
                         result_beats, name, want, got);
        end
    endfunction

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            cfg_q.dist_limit    = RST_DIST_LIMIT;
            cfg_q.start_timeout = RST_START_TIMEOUT;
            cfg_q.echo_timeout  = RST_ECHO_TIMEOUT;
            cfg_q.round_gap     = RST_ROUND_GAP;
            ph = PH_TRIG_LOW;
            sidx = SENS_FRONT;
            pcnt = '0;
            resid = '0;
            acc = '0;
            foreach (stored_cm[i])
                stored_cm[i] = '0;
            round_err = '0;
            expected_outputs.delete();
            fail_count = 0;
            result_beats = 0;
            pending_beats <= 0;
        end
        else
        begin
            // register write
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_DIST_LIMIT:    cfg_q.dist_limit    = cfg.data[DIST_W-1:0];
                    REG_START_TIMEOUT: cfg_q.start_timeout = cfg.data[TMO_W-1:0];
                    REG_ECHO_TIMEOUT:  cfg_q.echo_timeout  = cfg.data[TMO_W-1:0];
                    REG_ROUND_GAP:     cfg_q.round_gap     = cfg.data[GAP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // result beat against the oldest expectation
            if (result.valid && result.ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result beat %0d arrived with nothing expected", result_beats);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    compare_field("trig_front", DIST_W'(want.trig_front),
                                  DIST_W'(result.trig_front));
                    compare_field("trig_left", DIST_W'(want.trig_left),
                                  DIST_W'(result.trig_left));
                    compare_field("trig_right", DIST_W'(want.trig_right),
                                  DIST_W'(result.trig_right));
                    compare_field("front_cm", want.front_cm, result.front_cm);
                    compare_field("left_cm", want.left_cm, result.left_cm);
                    compare_field("right_cm", want.right_cm, result.right_cm);
                    compare_field("fail_mask", DIST_W'(want.fail_mask),
                                  DIST_W'(result.fail_mask));
                    compare_field("report_valid", DIST_W'(want.report_valid),
                                  DIST_W'(result.report_valid));
                end
                result_beats++;
            end

            // echo sample beat
            if (sample.valid && sample.ready)
                expected_outputs.push_back(step_sequencer({sample.echo_right, sample.echo_left,
                                                           sample.echo_front}));

            pending_beats <= expected_outputs.size();
        end
    end

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb
    import urs_pkg::*;
();

    localparam logic [2:0] ECHO_NONE = 3'b000;
    localparam logic [2:0] ECHO_ALL  = 3'b111;
    localparam int         RANDOM_TICKS = 240;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{REG_DIST_LIMIT, REG_START_TIMEOUT,
                                                       REG_ECHO_TIMEOUT, REG_ROUND_GAP};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned src_idle_pct = 20;
    int unsigned snk_idle_pct = 71;
    int          fail_count;
    int          pending_beats;
    int          random_ticks;
    int          burst;

    // per-line echo pulse generator
    logic [2:0]  pulse_level = '0;
    int          pulse_remain [3] = '{0, 0, 0};

    urs_sample_if sample_ch ();
    urs_result_if result_ch ();
    urs_cfg_if    cfg_ch ();

    ultrasonic_ranging_sequencer_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    ranging_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample_ch),
        .result        (result_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    always #1 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    // one echo tick, leaves valid high after the beat
    task automatic send_tick(input logic [2:0] echo);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.echo_front <= echo[0];
        sample_ch.echo_left  <= echo[1];
        sample_ch.echo_right <= echo[2];
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    task automatic hold_echo(input int n, input logic [2:0] echo);
        repeat (n)
            send_tick(echo);
    endtask

    // stop sampling until every owed output has come back
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats != 0);
    endtask

    // caller lowers valid after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DAT_W'(val);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    function automatic int unsigned pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (idx)
            REG_DIST_LIMIT:
                return (sel == 0) ? 0 : (sel == 1) ? 2047 : (sel == 2) ? 1034 :
                       $urandom_range(0, 4);
            REG_START_TIMEOUT:
                return (sel == 0) ? 0 : (sel == 1) ? 65535 : (sel == 2) ? 1 :
                       $urandom_range(1, 40);
            REG_ECHO_TIMEOUT:
                return (sel == 0) ? 0 : (sel == 1) ? 65535 : (sel == 2) ? 1 :
                       $urandom_range(20, 250);
            default:
                return (sel == 0 && $urandom_range(0, 2) == 0) ? 1048575 :
                       (sel < 4) ? 0 : $urandom_range(1, 12);
        endcase
    endfunction

    // mostly clean pulses on each line, a little glitch noise
    function automatic logic [2:0] random_echo();
        logic [2:0] e;
        for (int i = 0; i < 3; i++)
        begin
            if (pulse_remain[i] == 0)
            begin
                pulse_level[i] = ~pulse_level[i];
                if (pulse_level[i])
                    pulse_remain[i] = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 130) :
                                      $urandom_range(131, 400);
                else
                    pulse_remain[i] = $urandom_range(1, 45);
            end
            pulse_remain[i]--;
            e[i] = pulse_level[i] ^ ($urandom_range(0, 99) < 3);
        end
        return e;
    endfunction

    // stimulus and verdict
    initial
    begin
        sample_ch.valid      <= 1'b0;
        sample_ch.echo_front <= 1'b0;
        sample_ch.echo_left  <= 1'b0;
        sample_ch.echo_right <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_DIST_LIMIT;
        cfg_ch.data          <= '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // default registers: 3 cm front, left echo already high during trigger, 1 cm right
        hold_echo(12 + 3, ECHO_NONE);
        hold_echo(174, ECHO_ALL);
        hold_echo(1, ECHO_NONE);
        hold_echo(12 + 116, ECHO_ALL);
        hold_echo(1, ECHO_NONE);
        hold_echo(12, ECHO_NONE);
        hold_echo(58, ECHO_ALL);
        hold_echo(1, ECHO_NONE);

        // tightest timeouts, zero clamp, zero gap; block sits in the long gap
        wait_idle();
        write_reg(REG_ROUND_GAP, 0);
        write_reg(REG_START_TIMEOUT, 1);
        write_reg(REG_ECHO_TIMEOUT, 1);
        write_reg(REG_DIST_LIMIT, 0);
        cfg_ch.valid <= 1'b0;
        hold_echo(1, ECHO_NONE);
        // front passes with one high tick, left misses its rise, right echo too long
        hold_echo(12, ECHO_NONE);
        hold_echo(1, ECHO_ALL);
        hold_echo(1, ECHO_NONE);
        hold_echo(12 + 2, ECHO_NONE);
        hold_echo(12, ECHO_NONE);
        hold_echo(2, ECHO_ALL);

        // zero timeouts: every sensor fails on its first wait or high tick
        wait_idle();
        write_reg(REG_START_TIMEOUT, 0);
        write_reg(REG_ECHO_TIMEOUT, 0);
        cfg_ch.valid <= 1'b0;
        hold_echo(12 + 1, ECHO_NONE);
        hold_echo(12, ECHO_NONE);
        hold_echo(1, ECHO_ALL);
        hold_echo(12, ECHO_NONE);
        hold_echo(1, ECHO_ALL);

        // widest timeouts and gap, clamp at 2 cm
        wait_idle();
        write_reg(REG_DIST_LIMIT, 2);
        write_reg(REG_START_TIMEOUT, 65535);
        write_reg(REG_ECHO_TIMEOUT, 65535);
        write_reg(REG_ROUND_GAP, 1048575);
        cfg_ch.valid <= 1'b0;
        hold_echo(12 + 20, ECHO_NONE);
        hold_echo(174, ECHO_ALL);
        hold_echo(1, ECHO_NONE);
        hold_echo(12, ECHO_NONE);
        hold_echo(116, ECHO_ALL);
        hold_echo(1, ECHO_NONE);
        hold_echo(12 + 5, ECHO_NONE);
        hold_echo(58, ECHO_ALL);
        hold_echo(1, ECHO_NONE);
        hold_echo(30, ECHO_NONE);

        // shrink the gap below the ticks already spent in it
        wait_idle();
        write_reg(REG_ROUND_GAP, 1);
        cfg_ch.valid <= 1'b0;

        // random register settings with pulse trains in between
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS)
        begin
            if (random_ticks < RANDOM_TICKS / 2)
            begin
                src_idle_pct = 71;
                snk_idle_pct = 20;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            wait_idle();
            foreach (REG_ORDER[k])
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_ORDER[k], pick_reg_value(REG_ORDER[k]));
            cfg_ch.valid <= 1'b0;
            burst = $urandom_range(20, 60);
            repeat (burst)
                send_tick(random_echo());
            random_ticks += burst;
        end

        wait_idle();
        repeat (4)
            @(posedge clk);
        if (fail_count == 0 && pending_beats == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard
    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/urs_pkg.sv
hdl/urs_if.sv
hdl/urs_cfg_regs.sv
hdl/urs_seq.sv
hdl/urs_out_reg.sv
hdl/ultrasonic_ranging_sequencer_top.sv
dv/ranging_checker.sv
dv/tb.sv
